/* rtl/core/scc_pkg.sv */
// Shared types, constants and command tables for the serial camera capture sequencer.
// No dependencies; imported by every module of the block.
package scc_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned THRESH_W = 4;
   localparam int unsigned COUNT_W  = 4;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned POS_W    = 4;   // position within a burst, at most 16 items
   localparam int unsigned LEN_W    = 5;   // burst length up to 17 before the cap
   localparam logic [LEN_W-1:0] MAX_BURST = 5'd16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
   localparam logic [COUNT_W-1:0] CAPTURE_LIMIT = 4'd9;
   localparam logic [COUNT_W-1:0] LEN_HIGH_POS  = 4'd7;
   localparam logic [COUNT_W-1:0] LEN_LOW_POS   = 4'd8;

   // camera protocol bytes
   localparam logic [BYTE_W-1:0] BYTE_SYNC    = 8'h56;
   localparam logic [BYTE_W-1:0] BYTE_ZERO    = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_ONE     = 8'h01;
   localparam logic [BYTE_W-1:0] OPC_CTRL     = 8'h36;
   localparam logic [BYTE_W-1:0] OPC_SIZE     = 8'h34;
   localparam logic [BYTE_W-1:0] OPC_READ     = 8'h32;
   localparam logic [BYTE_W-1:0] ARG_IDLE     = 8'h03;
   localparam logic [BYTE_W-1:0] ARG_SHOT     = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_RD_LEN  = 8'h0C;
   localparam logic [BYTE_W-1:0] BYTE_DELAY   = 8'h0A;
   localparam logic [BYTE_W-1:0] MARK_START   = 8'hFF;
   localparam logic [BYTE_W-1:0] MARK_END     = 8'hD9;
   localparam logic [BYTE_W-1:0] MARK_TRAIL   = 8'h76;

   localparam logic [POS_W-1:0] IMG_LH_POS = 4'd12;
   localparam logic [POS_W-1:0] IMG_LL_POS = 4'd13;

   localparam logic [BYTE_W-1:0] IMAGE_CMD [16] = '{
      BYTE_SYNC, BYTE_ZERO, OPC_READ, BYTE_RD_LEN, BYTE_ZERO, BYTE_DELAY, BYTE_ZERO, BYTE_ZERO,
      BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_DELAY
   };

   typedef enum logic {
      OP_START = 1'b0,
      OP_RX    = 1'b1
   } op_type;

   typedef enum logic {
      DEST_CAMERA = 1'b0,
      DEST_HOST   = 1'b1
   } dest_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IDLE_TH = 2'd0,
      CSR_SHOT_TH = 2'd1,
      CSR_SIZE_TH = 2'd2
   } csr_idx_type;

   typedef enum logic [3:0] {
      PH_NONE = 4'b0001,
      PH_IDLE = 4'b0010,
      PH_SHOT = 4'b0100,
      PH_SIZE = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_IDLE  = 3'd1,
      CMD_SHOT  = 3'd2,
      CMD_SIZE  = 3'd3,
      CMD_IMAGE = 3'd4
   } cmd_type;

   // one burst of result items caused by a single input item
   typedef struct packed {
      logic              fwd;
      logic [BYTE_W-1:0] fwd_byte;
      cmd_type           cmd;
      logic [BYTE_W-1:0] len_high;
      logic [BYTE_W-1:0] len_low;
   } burst_type;

   function automatic logic [LEN_W-1:0] cmd_len(input cmd_type cmd);
      logic [LEN_W-1:0] len;
      case (cmd)
         CMD_IDLE, CMD_SHOT, CMD_SIZE: len = 5'd5;
         CMD_IMAGE:                    len = 5'd16;
         default:                      len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [BYTE_W-1:0] short_cmd_byte(input logic [POS_W-1:0] pos,
                                                         input logic [BYTE_W-1:0] opc,
                                                         input logic [BYTE_W-1:0] arg);
      logic [BYTE_W-1:0] b;
      case (pos)
         4'd0:    b = BYTE_SYNC;
         4'd1:    b = BYTE_ZERO;
         4'd2:    b = opc;
         4'd3:    b = BYTE_ONE;
         4'd4:    b = arg;
         default: b = BYTE_ZERO;
      endcase
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] cmd_byte(input cmd_type cmd,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [BYTE_W-1:0] len_high,
                                                   input logic [BYTE_W-1:0] len_low);
      logic [BYTE_W-1:0] b;
      case (cmd)
         CMD_IDLE: b = short_cmd_byte(pos, OPC_CTRL, ARG_IDLE);
         CMD_SHOT: b = short_cmd_byte(pos, OPC_CTRL, ARG_SHOT);
         CMD_SIZE: b = short_cmd_byte(pos, OPC_SIZE, BYTE_ZERO);
         CMD_IMAGE: begin
            if (pos == IMG_LH_POS)      b = len_high;
            else if (pos == IMG_LL_POS) b = len_low;
            else                        b = IMAGE_CMD[pos];
         end
         default: b = BYTE_ZERO;
      endcase
      return b;
   endfunction

endpackage

/* rtl/core/scc_if.sv */
// Handshake channel interfaces of the serial camera capture sequencer.
// Depends on scc_pkg for field widths.
interface scc_req_if import scc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, output op, output rx_byte, input ready);
   modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface scc_rsp_if import scc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              destination;
   logic [BYTE_W-1:0] data_byte;
   logic              last;
   modport source (output valid, output destination, output data_byte, output last, input ready);
   modport sink (input valid, input destination, input data_byte, input last, output ready);
endinterface

interface scc_csr_if import scc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [THRESH_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/scc_ctrl.sv */
// Capture sequencer state: phases, reply counting, size capture and marker tracking.
// Builds one burst descriptor per item. Depends on scc_pkg and scc_if.
module scc_ctrl
   import scc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   scc_req_if.sink   req_if,
   scc_csr_if.sink   csr_if,
   input  logic      burst_ready_i,
   output logic      burst_load_o,
   output burst_type burst_o
);

   phase_type           phase_ff, phase_in;
   logic [COUNT_W-1:0]  reply_count_ff, reply_count_in;
   logic                size_capture_ff, size_capture_in;
   logic [COUNT_W-1:0]  capture_index_ff, capture_index_in;
   logic [BYTE_W-1:0]   length_high_ff, length_high_in;
   logic [BYTE_W-1:0]   length_low_ff, length_low_in;
   logic                image_fetch_ff, image_fetch_in;
   logic                forwarding_ff, forwarding_in;
   logic                saw_end_ff, saw_end_in;
   logic [THRESH_W-1:0] idle_th_ff, shot_th_ff, size_th_ff;
   logic                accept;
   burst_type           burst;

   assign req_if.ready = burst_ready_i;
   assign accept       = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_th_ff <= 4'd3;
         shot_th_ff <= 4'd5;
         size_th_ff <= 4'd9;
      end else if (csr_if.valid) begin
         case (csr_idx_type'(csr_if.index))
            CSR_IDLE_TH: idle_th_ff <= csr_if.data;
            CSR_SHOT_TH: shot_th_ff <= csr_if.data;
            CSR_SIZE_TH: size_th_ff <= csr_if.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      reply_count_in   = reply_count_ff;
      size_capture_in  = size_capture_ff;
      capture_index_in = capture_index_ff;
      length_high_in   = length_high_ff;
      length_low_in    = length_low_ff;
      image_fetch_in   = image_fetch_ff;
      forwarding_in    = forwarding_ff;
      saw_end_in       = saw_end_ff;
      burst.fwd        = 1'b0;
      burst.fwd_byte   = req_if.rx_byte;
      burst.cmd        = CMD_NONE;

      if (op_type'(req_if.op) == OP_START) begin
         length_high_in   = BYTE_ZERO;
         length_low_in    = BYTE_ZERO;
         phase_in         = PH_IDLE;
         reply_count_in   = '0;
         capture_index_in = '0;
         image_fetch_in   = 1'b0;
         forwarding_in    = 1'b0;
         burst.cmd        = CMD_IDLE;
      end else begin
         if (phase_ff != PH_NONE && reply_count_ff != COUNT_MAX)
            reply_count_in = reply_count_ff + 4'd1;

         if (size_capture_ff) begin
            if (capture_index_ff == LEN_HIGH_POS)     length_high_in = req_if.rx_byte;
            else if (capture_index_ff == LEN_LOW_POS) length_low_in  = req_if.rx_byte;
            if (capture_index_ff < CAPTURE_LIMIT)
               capture_index_in = capture_index_ff + 4'd1;
         end

         if (req_if.rx_byte == MARK_START) forwarding_in = 1'b1;
         if (req_if.rx_byte == MARK_END) begin
            saw_end_in = 1'b1;
         end else if (req_if.rx_byte == MARK_TRAIL && saw_end_ff) begin
            // end of image: drop forwarding and the stored length
            forwarding_in  = 1'b0;
            saw_end_in     = 1'b0;
            length_high_in = BYTE_ZERO;
            length_low_in  = BYTE_ZERO;
         end else begin
            saw_end_in = 1'b0;
         end

         burst.fwd = image_fetch_ff && forwarding_in;

         case (phase_ff)
            PH_IDLE: begin
               if (reply_count_in >= idle_th_ff) begin
                  phase_in         = PH_SHOT;
                  reply_count_in   = '0;
                  capture_index_in = '0;
                  burst.cmd        = CMD_SHOT;
               end
            end
            PH_SHOT: begin
               if (reply_count_in >= shot_th_ff) begin
                  phase_in        = PH_SIZE;
                  reply_count_in  = '0;
                  size_capture_in = 1'b1;
                  burst.cmd       = CMD_SIZE;
               end
            end
            PH_SIZE: begin
               if (reply_count_in >= size_th_ff) begin
                  phase_in         = PH_NONE;
                  reply_count_in   = '0;
                  size_capture_in  = 1'b0;
                  image_fetch_in   = 1'b1;
                  forwarding_in    = 1'b0;
                  capture_index_in = '0;
                  burst.cmd        = CMD_IMAGE;
               end
            end
            default: ;
         endcase
      end
      // length bytes as they stand after this item
      burst.len_high = length_high_in;
      burst.len_low  = length_low_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_NONE;
         reply_count_ff   <= '0;
         size_capture_ff  <= 1'b0;
         capture_index_ff <= '0;
         length_high_ff   <= '0;
         length_low_ff    <= '0;
         image_fetch_ff   <= 1'b0;
         forwarding_ff    <= 1'b0;
         saw_end_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         reply_count_ff   <= reply_count_in;
         size_capture_ff  <= size_capture_in;
         capture_index_ff <= capture_index_in;
         length_high_ff   <= length_high_in;
         length_low_ff    <= length_low_in;
         image_fetch_ff   <= image_fetch_in;
         forwarding_ff    <= forwarding_in;
         saw_end_ff       <= saw_end_in;
      end
   end

   assign burst_load_o = accept && (burst.fwd || burst.cmd != CMD_NONE);
   assign burst_o      = burst;

   a_start_enters_idle: assert property (@(posedge clock) disable iff (reset)
      accept && op_type'(req_if.op) == OP_START |=> phase_ff == PH_IDLE && !image_fetch_ff)
      else $error("start item did not enter idle phase");

   a_capture_index_sat: assert property (@(posedge clock) disable iff (reset)
      capture_index_ff <= CAPTURE_LIMIT)
      else $error("capture index beyond saturation");

   a_image_request_arms: assert property (@(posedge clock) disable iff (reset)
      accept && burst.cmd == CMD_IMAGE |=> image_fetch_ff && phase_ff == PH_NONE
                                          && !size_capture_ff)
      else $error("image request did not arm fetch");

endmodule

/* rtl/core/scc_emit.sv */
// Burst emitter: holds one burst descriptor and streams its items on the result channel.
// Depends on scc_pkg and scc_if.
module scc_emit
   import scc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      burst_load_i,
   input  burst_type burst_i,
   output logic      burst_ready_o,
   scc_rsp_if.source rsp_if
);

   logic              busy_ff;
   burst_type         desc_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  total, total_capped, total_m1;
   logic [POS_W-1:0]  cmd_pos;
   logic              fire, last_fire;

   assign total        = LEN_W'(desc_ff.fwd) + cmd_len(desc_ff.cmd);
   assign total_capped = (total > MAX_BURST) ? MAX_BURST : total;
   assign total_m1     = total_capped - 5'd1;
   assign cmd_pos      = pos_ff - POS_W'(desc_ff.fwd);

   assign rsp_if.valid = busy_ff;
   assign rsp_if.last  = (pos_ff == total_m1[POS_W-1:0]);
   always_comb begin
      if (desc_ff.fwd && pos_ff == '0) begin
         rsp_if.destination = DEST_HOST;
         rsp_if.data_byte   = desc_ff.fwd_byte;
      end else begin
         rsp_if.destination = DEST_CAMERA;
         rsp_if.data_byte   = cmd_byte(desc_ff.cmd, cmd_pos, desc_ff.len_high,
                                       desc_ff.len_low);
      end
   end

   assign fire          = rsp_if.valid && rsp_if.ready;
   assign last_fire     = fire && rsp_if.last;
   // a new burst may enter in the cycle the final item of the current one leaves
   assign burst_ready_o = !busy_ff || last_fire;
   assign pos_in        = burst_load_i ? '0 : (fire ? pos_ff + 4'd1 : pos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         if (burst_load_i)   busy_ff <= 1'b1;
         else if (last_fire) busy_ff <= 1'b0;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (burst_load_i) desc_ff <= burst_i;
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      burst_load_i |-> burst_ready_o)
      else $error("burst loaded over one still in flight");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      fire && !rsp_if.last |=> busy_ff && pos_ff == $past(pos_ff) + 4'd1)
      else $error("burst broken before its last item");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pos_ff <= total_m1[POS_W-1:0])
      else $error("burst position beyond its length");

endmodule

/* rtl/core/serial_camera_capture_sequencer.sv */
// Serial camera capture sequencer, top level. Uses scc_pkg, scc_if, scc_ctrl, scc_emit.
// Latency: first result item is offered the cycle after its input item is accepted.
// Throughput: one input item per cycle while no burst is pending. Any input item waits
// while a burst of N result items (N up to 16) drains and enters as its last item leaves;
// result-side stalls lengthen the wait.
// Reset (synchronous, active high) returns the thresholds to 3/5/9 and clears all state but the held burst descriptor.
module serial_camera_capture_sequencer
   import scc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   scc_req_if.sink   req_if,
   scc_rsp_if.source rsp_if,
   scc_csr_if.sink   csr_if
);

   logic      burst_ready;
   logic      burst_load;
   burst_type burst;

   scc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .csr_if        (csr_if),
      .burst_ready_i (burst_ready),
      .burst_load_o  (burst_load),
      .burst_o       (burst)
   );

   scc_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .burst_load_i  (burst_load),
      .burst_i       (burst),
      .burst_ready_o (burst_ready),
      .rsp_if        (rsp_if)
   );

endmodule
